// ===== src/assert_macros.svh =====
// assertion macros shared by the engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mst_pkg.sv =====
// types, constants and sigmoid table of the sigmoid network engine
`timescale 1ns / 1ps

package mst_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ONE_FX    = 1 << FRAC_BITS;

   typedef enum logic [2:0] {
      OP_WRITE_WEIGHT = 3'd0,
      OP_WRITE_BIAS   = 3'd1,
      OP_WRITE_INPUT  = 3'd2,
      OP_FORWARD      = 3'd3,
      OP_TRAIN        = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CSR_NUM_LAYERS    = 3'd0,
      CSR_SIZE_LAYER0   = 3'd1,
      CSR_SIZE_LAYER1   = 3'd2,
      CSR_SIZE_LAYER2   = 3'd3,
      CSR_SIZE_LAYER3   = 3'd4,
      CSR_LEARNING_RATE = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_MAC,
      ST_FWD_DRAIN,
      ST_FWD_ACT,
      ST_TR_OUT_RD,
      ST_TR_OUT_LD,
      ST_TR_HID_MAC,
      ST_TR_HID_DRAIN,
      ST_TR_HID_LD,
      ST_ERR_M1,
      ST_ERR_M2,
      ST_ERR_WR,
      ST_UPD_RD,
      ST_UPD_G,
      ST_UPD_MAC,
      ST_UPD_DRAIN
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [1:0]         layer_index;
      logic [3:0]         neuron_index;
      logic [3:0]         source_index;
      logic signed [15:0] param_value;
      logic signed [3:0]  sample_value;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  out_neuron;
      logic [12:0] activation;
      logic        last;
   } rsp_payload_type;

   typedef logic [12:0] sig_table_type [256];

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   p [129];
      logic [63:0]   num;
      logic [63:0]   den;
      logic [63:0]   dividend;
      logic [63:0]   rem;
      logic [63:0]   quo;
      int            i;
      int            b;
      int            k;
      p[0] = 64'd1 << 30;
      for (i = 1; i <= 128; i++) begin
         p[i] = (p[i - 1] * 64'd1008687095 + (64'd1 << 29)) >> 30;
      end
      for (i = 0; i < 256; i++) begin
         k = (i >= 128) ? i - 128 : 128 - i;
         den = (64'd1 << 30) + p[k];
         num = (i >= 128) ? (64'd1 << 30) : p[k];
         dividend = (num << FRAC_BITS) + (den >> 1);
         rem = '0;
         quo = '0;
         for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], dividend[b]};
            if (rem >= den) begin
               rem = rem - den;
               quo[b] = 1'b1;
            end
         end
         tbl[i] = quo[12:0];
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) begin
         return 16'sh7fff;
      end else if (v < -40'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // layer size register to index of its last neuron
   function automatic logic [3:0] size_last(input logic [4:0] sz);
      if (sz == 5'd0) begin
         return 4'd0;
      end else if (sz > 5'd16) begin
         return 4'd15;
      end
      return 4'(sz - 5'd1);
   endfunction

endpackage

// ===== src/mst_chan_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps

interface mst_req_if;
   import mst_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mst_rsp_if;
   import mst_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/mst_act_unit.sv =====
// weighted sum plus bias through saturation and the sigmoid table
`timescale 1ns / 1ps

module mst_act_unit (
   input  logic signed [35:0] acc,
   input  logic signed [15:0] bias,
   output logic [12:0]        act
);
   import mst_pkg::*;

   logic signed [15:0] z;
   logic [7:0]         idx;

   always_comb begin
      z = sat16(40'($signed(acc[35:12])) + 40'(bias));
      idx = {~z[15], z[14:8]};
      act = SIG_TABLE[idx];
   end

endmodule

// ===== src/mlp_sigmoid_train_engine.sv =====
// sigmoid network engine: write, forward and train sequencer over weight and state memories
// forward: per neuron one mac per cycle over the previous layer, then drain and activate
// train: output neuron read, load, multiply, error write; hidden neuron mac over next layer,
// drain, load, multiply, error write; update read, gradient, mac over previous layer, drain;
// one weight port pair paces this; writes act on accept; results leave via an output register
// reset is synchronous: config registers to defaults, activations read as zero, engine idle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlp_sigmoid_train_engine (
   input  logic       clock,
   input  logic       reset,
   mst_req_if.sink    req_chan,
   mst_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [12:0] csr_wdata
);
   import mst_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] layer_ff, layer_in;
   logic [3:0] j_ff, j_in;
   logic [3:0] k_ff, k_in;
   logic signed [35:0] acc_ff, acc_in;
   logic mac_en_ff, mac_en_in;
   logic signed [3:0] target_ff, target_in;
   logic signed [23:0] s_ff, s_in;
   logic [12:0] o_ff, o_in;
   logic signed [25:0] p1_ff, p1_in;
   logic signed [27:0] p2_ff, p2_in;
   logic signed [17:0] g_ff, g_in;
   logic upd_pend_ff, upd_pend_in;
   logic [9:0] waddr_ff, waddr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [2:0]  num_layers_ff;
   logic [4:0]  size_ff [4];
   logic [12:0] lr_ff;

   logic [15:0] weight_mem [1024];
   logic [15:0] bias_mem [64];
   logic [15:0] act_mem [64];
   logic [15:0] err_mem [64];
   logic [63:0] act_vld_ff;

   logic signed [15:0] w_rd_ff, b_rd_ff, a_rd_ff, e_rd_ff;
   logic a_rd_vld_ff;

   logic [9:0] w_raddr, w_waddr;
   logic [5:0] b_waddr, a_raddr, a_waddr, e_raddr;
   logic w_we, b_we, a_we, e_we;
   logic signed [15:0] w_wdata, b_wdata, a_wdata;

   logic req_accept;
   logic [1:0] top_layer;
   logic [3:0] cur_last, prev_last, next_last, kmax;
   logic k_done, j_done, is_top, fwd_hold;
   logic signed [15:0] a_op;
   logic signed [31:0] mac_prod;
   logic signed [37:0] prod1;
   logic signed [39:0] prod2;
   logic signed [29:0] gprod;
   logic signed [33:0] dprod;
   logic [12:0] act_val;
   req_payload_type req;

   assign req = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   mst_act_unit u_act (
      .acc  (acc_ff),
      .bias (b_rd_ff),
      .act  (act_val)
   );

   // shared decode
   always_comb begin
      if (num_layers_ff <= 3'd2) begin
         top_layer = 2'd1;
      end else if (num_layers_ff == 3'd3) begin
         top_layer = 2'd2;
      end else begin
         top_layer = 2'd3;
      end
      cur_last = size_last(size_ff[layer_ff]);
      prev_last = size_last(size_ff[layer_ff - 2'd1]);
      next_last = size_last(size_ff[layer_ff + 2'd1]);
      kmax = (state_ff == ST_TR_HID_MAC) ? next_last : prev_last;
      k_done = (k_ff == kmax);
      j_done = (j_ff == cur_last);
      is_top = (layer_ff == top_layer);
      fwd_hold = (state_ff == ST_FWD_ACT) && is_top && rsp_valid_ff && !rsp_chan.ready;
      a_op = a_rd_vld_ff ? a_rd_ff : 16'sd0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req.opcode == OP_FORWARD) begin
               state_in = ST_FWD_MAC;
            end else if (req_accept && req.opcode == OP_TRAIN) begin
               state_in = ST_TR_OUT_RD;
            end
         end
         ST_FWD_MAC: begin
            if (k_done) begin
               state_in = ST_FWD_DRAIN;
            end
         end
         ST_FWD_DRAIN: state_in = ST_FWD_ACT;
         ST_FWD_ACT: begin
            if (!fwd_hold) begin
               state_in = (j_done && is_top) ? ST_IDLE : ST_FWD_MAC;
            end
         end
         ST_TR_OUT_RD: state_in = ST_TR_OUT_LD;
         ST_TR_OUT_LD: state_in = ST_ERR_M1;
         ST_TR_HID_MAC: begin
            if (k_done) begin
               state_in = ST_TR_HID_DRAIN;
            end
         end
         ST_TR_HID_DRAIN: state_in = ST_TR_HID_LD;
         ST_TR_HID_LD: state_in = ST_ERR_M1;
         ST_ERR_M1: state_in = ST_ERR_M2;
         ST_ERR_M2: state_in = ST_ERR_WR;
         ST_ERR_WR: begin
            if (!j_done) begin
               state_in = is_top ? ST_TR_OUT_RD : ST_TR_HID_MAC;
            end else if (layer_ff == 2'd1) begin
               state_in = ST_UPD_RD;
            end else begin
               state_in = ST_TR_HID_MAC;
            end
         end
         ST_UPD_RD: state_in = ST_UPD_G;
         ST_UPD_G: state_in = ST_UPD_MAC;
         ST_UPD_MAC: begin
            if (k_done) begin
               state_in = ST_UPD_DRAIN;
            end
         end
         ST_UPD_DRAIN: begin
            state_in = (j_done && is_top) ? ST_IDLE : ST_UPD_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      layer_in = layer_ff;
      j_in = j_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      target_in = target_ff;
      s_in = s_ff;
      o_in = o_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      g_in = g_ff;
      mac_en_in = (state_ff == ST_FWD_MAC) || (state_ff == ST_TR_HID_MAC);
      upd_pend_in = (state_ff == ST_UPD_MAC);
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      mac_prod = ((state_ff == ST_TR_HID_MAC) || (state_ff == ST_TR_HID_DRAIN))
                 ? w_rd_ff * e_rd_ff : a_op * w_rd_ff;
      prod1 = s_ff * $signed({1'b0, o_ff});
      prod2 = p1_ff * $signed(14'(ONE_FX) - {1'b0, o_ff});
      gprod = $signed({1'b0, lr_ff}) * e_rd_ff;
      dprod = g_ff * a_op;

      w_raddr = {layer_ff, j_ff, k_ff};
      a_raddr = {layer_ff, j_ff};
      e_raddr = {layer_ff, j_ff};
      w_we = 1'b0;
      w_waddr = waddr_ff;
      w_wdata = sat16(40'(w_rd_ff) - 40'($signed(dprod[33:12])));
      b_we = 1'b0;
      b_waddr = {layer_ff, j_ff};
      b_wdata = sat16(40'(b_rd_ff) - 40'(g_ff));
      a_we = 1'b0;
      a_waddr = {layer_ff, j_ff};
      a_wdata = {3'b000, act_val};
      e_we = 1'b0;

      if (mac_en_ff) begin
         acc_in = acc_ff + 36'(mac_prod);
      end
      if (upd_pend_ff) begin
         w_we = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            acc_in = '0;
            k_in = '0;
            j_in = '0;
            if (req_accept) begin
               case (req.opcode)
                  OP_WRITE_WEIGHT: begin
                     w_we = 1'b1;
                     w_waddr = {req.layer_index, req.neuron_index, req.source_index};
                     w_wdata = req.param_value;
                  end
                  OP_WRITE_BIAS: begin
                     b_we = 1'b1;
                     b_waddr = {req.layer_index, req.neuron_index};
                     b_wdata = req.param_value;
                  end
                  OP_WRITE_INPUT: begin
                     a_we = 1'b1;
                     a_waddr = {2'b00, req.neuron_index};
                     a_wdata = {req.sample_value, 12'h000};
                  end
                  OP_FORWARD: layer_in = 2'd1;
                  OP_TRAIN: begin
                     layer_in = top_layer;
                     target_in = req.sample_value;
                  end
                  default: ;
               endcase
            end
         end
         ST_FWD_MAC: begin
            a_raddr = {layer_ff - 2'd1, k_ff};
            k_in = k_done ? 4'd0 : k_ff + 4'd1;
         end
         ST_FWD_ACT: begin
            if (!fwd_hold) begin
               a_we = 1'b1;
               acc_in = '0;
               j_in = j_done ? 4'd0 : j_ff + 4'd1;
               layer_in = j_done ? layer_ff + 2'd1 : layer_ff;
               if (is_top) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.out_neuron = j_ff;
                  rsp_data_in.activation = act_val;
                  rsp_data_in.last = j_done;
               end
            end
         end
         ST_TR_OUT_LD: begin
            o_in = a_op[12:0];
            s_in = $signed({11'b0, a_op[12:0]}) - {{8{target_ff[3]}}, target_ff, 12'h000};
         end
         ST_TR_HID_MAC: begin
            w_raddr = {layer_ff + 2'd1, k_ff, j_ff};
            e_raddr = {layer_ff + 2'd1, k_ff};
            k_in = k_done ? 4'd0 : k_ff + 4'd1;
         end
         ST_TR_HID_LD: begin
            o_in = a_op[12:0];
            s_in = acc_ff[35:12];
            acc_in = '0;
         end
         ST_ERR_M1: p1_in = prod1[37:12];
         ST_ERR_M2: p2_in = prod2[39:12];
         ST_ERR_WR: begin
            e_we = 1'b1;
            k_in = '0;
            if (j_done) begin
               j_in = '0;
               layer_in = (layer_ff == 2'd1) ? layer_ff : layer_ff - 2'd1;
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         ST_UPD_G: g_in = gprod[29:12];
         ST_UPD_MAC: begin
            a_raddr = {layer_ff - 2'd1, k_ff};
            k_in = k_done ? 4'd0 : k_ff + 4'd1;
         end
         ST_UPD_DRAIN: begin
            b_we = 1'b1;
            j_in = j_done ? 4'd0 : j_ff + 4'd1;
            layer_in = j_done ? layer_ff + 2'd1 : layer_ff;
         end
         default: ;
      endcase
      waddr_in = w_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mac_en_ff <= 1'b0;
         upd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         act_vld_ff <= '0;
         num_layers_ff <= 3'd3;
         size_ff[0] <= 5'd16;
         size_ff[1] <= 5'd16;
         size_ff[2] <= 5'd16;
         size_ff[3] <= 5'd16;
         lr_ff <= 13'd410;
      end else begin
         state_ff <= state_in;
         mac_en_ff <= mac_en_in;
         upd_pend_ff <= upd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (a_we) begin
            act_vld_ff[a_waddr] <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_LAYERS: num_layers_ff <= csr_wdata[2:0];
               CSR_SIZE_LAYER0: size_ff[0] <= csr_wdata[4:0];
               CSR_SIZE_LAYER1: size_ff[1] <= csr_wdata[4:0];
               CSR_SIZE_LAYER2: size_ff[2] <= csr_wdata[4:0];
               CSR_SIZE_LAYER3: size_ff[3] <= csr_wdata[4:0];
               CSR_LEARNING_RATE: lr_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      layer_ff <= layer_in;
      j_ff <= j_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      target_ff <= target_in;
      s_ff <= s_in;
      o_ff <= o_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      g_ff <= g_in;
      waddr_ff <= waddr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      w_rd_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[b_waddr] <= b_wdata;
      end
      b_rd_ff <= bias_mem[{layer_ff, j_ff}];
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         act_mem[a_waddr] <= a_wdata;
      end
      a_rd_ff <= act_mem[a_raddr];
      a_rd_vld_ff <= act_vld_ff[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (e_we) begin
         err_mem[{layer_ff, j_ff}] <= sat16(40'(p2_ff));
      end
      e_rd_ff <= err_mem[e_raddr];
   end

   `MST_ASSERT_NEXT(a_out_stall_holds, clock, reset, fwd_hold, state_ff == ST_FWD_ACT, "output stall lost")
   `MST_ASSERT_IMPLY(a_rsp_from_act, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FWD_ACT, "result without activation")
   `MST_ASSERT_IMPLY(a_upd_write_phase, clock, reset, upd_pend_ff, state_ff == ST_UPD_MAC || state_ff == ST_UPD_DRAIN, "weight update outside update phase")
   `MST_ASSERT_NEXT(a_fwd_start, clock, reset, req_accept && req.opcode == OP_FORWARD, state_ff == ST_FWD_MAC && layer_ff == 2'd1, "forward did not start")

endmodule

// ===== sim/mlp_sigmoid_train_engine_tb.sv =====
// testbench for the sigmoid network engine: random and directed commands checked by a scoreboard
`timescale 1ns / 1ps

module mlp_sigmoid_train_engine_tb;
   import mst_pkg::*;

   localparam int  CYCLE_LIMIT  = 1_000_000;
   localparam int  DRAIN_CYCLES = 1500;
   localparam int  STALL_CYCLES = 3000;
   localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;

   class network_scoreboard;
      longint          weight_mem [1024];
      longint          bias_mem [64];
      longint          act_mem [64];
      longint          err_mem [64];
      int              sig_lut [256];
      logic [2:0]      layers_reg;
      logic [4:0]      size_reg [4];
      logic [12:0]     rate_reg;
      rsp_payload_type activation_q [$];
      int              errors;

      function new();
         longint unsigned p [129];
         longint unsigned num;
         longint unsigned den;
         int              k;
         p[0] = 64'd1 << 30;
         for (int i = 1; i <= 128; i++) begin
            p[i] = (p[i - 1] * 64'd1008687095 + (64'd1 << 29)) >> 30;
         end
         for (int i = 0; i < 256; i++) begin
            k = (i >= 128) ? i - 128 : 128 - i;
            den = (64'd1 << 30) + p[k];
            num = (i >= 128) ? (64'd1 << 30) : p[k];
            sig_lut[i] = int'(((num << FRAC_BITS) + den / 2) / den);
         end
         foreach (act_mem[i]) begin
            act_mem[i] = 0;
            err_mem[i] = 0;
            bias_mem[i] = 0;
         end
         foreach (weight_mem[i]) weight_mem[i] = 0;
         layers_reg = 3;
         foreach (size_reg[i]) size_reg[i] = 16;
         rate_reg = 410;
         errors = 0;
      endfunction

      function int layers_used();
         if (layers_reg < 2) return 2;
         if (layers_reg > 4) return 4;
         return layers_reg;
      endfunction

      function int layer_size(int l);
         if (size_reg[l] == 0) return 1;
         if (size_reg[l] > 16) return 16;
         return size_reg[l];
      endfunction

      function longint sat(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint squash(longint z);
         longint idx;
         idx = (z >>> (FRAC_BITS - 4)) + 128;
         if (idx < 0) idx = 0;
         if (idx > 255) idx = 255;
         return sig_lut[idx];
      endfunction

      function longint delta(longint s, longint o);
         return sat((((s * o) >>> FRAC_BITS) * (ONE_FX - o)) >>> FRAC_BITS);
      endfunction

      function int widx(int l, int j, int k);
         return (l * 16 + j) * 16 + k;
      endfunction

      function void write_reg(csr_index_type idx, logic [12:0] v);
         case (idx)
            CSR_NUM_LAYERS:    layers_reg = v[2:0];
            CSR_SIZE_LAYER0:   size_reg[0] = v[4:0];
            CSR_SIZE_LAYER1:   size_reg[1] = v[4:0];
            CSR_SIZE_LAYER2:   size_reg[2] = v[4:0];
            CSR_SIZE_LAYER3:   size_reg[3] = v[4:0];
            CSR_LEARNING_RATE: rate_reg = v;
            default: ;
         endcase
      endfunction

      function void run_forward();
         int              nl;
         int              m;
         int              n;
         longint          acc;
         rsp_payload_type r;
         nl = layers_used();
         for (int l = 1; l < nl; l++) begin
            m = layer_size(l - 1);
            n = layer_size(l);
            for (int j = 0; j < n; j++) begin
               acc = 0;
               for (int k = 0; k < m; k++)
                  acc += act_mem[(l - 1) * 16 + k] * weight_mem[widx(l, j, k)];
               acc = (acc >>> FRAC_BITS) + bias_mem[l * 16 + j];
               act_mem[l * 16 + j] = squash(sat(acc));
            end
         end
         n = layer_size(nl - 1);
         for (int j = 0; j < n; j++) begin
            r.out_neuron = 4'(j);
            r.activation = 13'(act_mem[(nl - 1) * 16 + j]);
            r.last = (j == n - 1);
            activation_q.push_back(r);
         end
      endfunction

      function void run_train(longint target);
         int     nl;
         int     top;
         int     n;
         int     m;
         longint o;
         longint s;
         longint g;
         longint d;
         nl = layers_used();
         top = nl - 1;
         n = layer_size(top);
         for (int j = 0; j < n; j++) begin
            o = act_mem[top * 16 + j];
            err_mem[top * 16 + j] = delta(o - target * ONE_FX, o);
         end
         for (int l = top - 1; l >= 1; l--) begin
            m = layer_size(l + 1);
            n = layer_size(l);
            for (int j = 0; j < n; j++) begin
               s = 0;
               o = act_mem[l * 16 + j];
               for (int k = 0; k < m; k++)
                  s += weight_mem[widx(l + 1, k, j)] * err_mem[(l + 1) * 16 + k];
               err_mem[l * 16 + j] = delta(s >>> FRAC_BITS, o);
            end
         end
         for (int l = 1; l < nl; l++) begin
            m = layer_size(l - 1);
            n = layer_size(l);
            for (int j = 0; j < n; j++) begin
               g = (longint'(rate_reg) * err_mem[l * 16 + j]) >>> FRAC_BITS;
               for (int k = 0; k < m; k++) begin
                  d = (g * act_mem[(l - 1) * 16 + k]) >>> FRAC_BITS;
                  weight_mem[widx(l, j, k)] = sat(weight_mem[widx(l, j, k)] - d);
               end
               bias_mem[l * 16 + j] = sat(bias_mem[l * 16 + j] - g);
            end
         end
      endfunction

      function void note_request(req_payload_type t);
         case (t.opcode)
            OP_WRITE_WEIGHT:
               weight_mem[widx(t.layer_index, t.neuron_index, t.source_index)] = t.param_value;
            OP_WRITE_BIAS: bias_mem[t.layer_index * 16 + t.neuron_index] = t.param_value;
            OP_WRITE_INPUT: act_mem[t.neuron_index] = sat(longint'(t.sample_value) * ONE_FX);
            OP_FORWARD: run_forward();
            OP_TRAIN: run_train(longint'(t.sample_value));
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check(rsp_payload_type got);
         rsp_payload_type want;
         if (activation_q.size() == 0) begin
            report($sformatf("unexpected transaction %p", got));
            return;
         end
         want = activation_q.pop_front();
         if (got.out_neuron !== want.out_neuron)
            report($sformatf("out_neuron %0d, wanted %0d", got.out_neuron, want.out_neuron));
         if (got.activation !== want.activation)
            report($sformatf("activation %0d, wanted %0d", got.activation, want.activation));
         if (got.last !== want.last)
            report($sformatf("last %0d, wanted %0d", got.last, want.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [12:0] csr_wdata;

   mst_req_if req_chan();
   mst_rsp_if rsp_chan();

   mlp_sigmoid_train_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   network_scoreboard sb = new();
   bit  weight_known [4][16][16];
   bit  bias_known [4][16];
   bit  quiet;
   bit  stall_start;
   int  stall_left;
   int  cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) sb.note_request(req_chan.payload);
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check(rsp_chan.payload);
   end

   // response side back-pressure, with a long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_start) begin
            stall_start = 0;
            stall_left = STALL_CYCLES;
         end
         rsp_chan.ready <= (stall_left == 0) && (quiet || $urandom_range(0, 99) >= 13);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [12:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(op_type op, int layer, int neuron, int source, int param, int sample);
      req_payload_type t;
      if (!quiet && $urandom_range(0, 99) < 13) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      t.opcode = op;
      t.layer_index = 2'(layer);
      t.neuron_index = 4'(neuron);
      t.source_index = 4'(source);
      t.param_value = 16'(param);
      t.sample_value = 4'(sample);
      if (op == OP_WRITE_WEIGHT) weight_known[layer][neuron][source] = 1'b1;
      if (op == OP_WRITE_BIAS) bias_known[layer][neuron] = 1'b1;
      req_chan.valid <= 1'b1;
      req_chan.payload <= t;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic int rand_param();
      case ($urandom_range(0, 9))
         0: return 32767;
         1: return -32768;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom_range(0, 16384) - 8192;
      endcase
   endfunction

   // every weight and bias that a command will read gets a value first
   task automatic fill_params();
      int nl;
      nl = sb.layers_used();
      for (int l = 1; l < nl; l++)
         for (int j = 0; j < sb.layer_size(l); j++) begin
            for (int k = 0; k < sb.layer_size(l - 1); k++)
               if (!weight_known[l][j][k]) send(OP_WRITE_WEIGHT, l, j, k, rand_param(), 0);
            if (!bias_known[l][j]) send(OP_WRITE_BIAS, l, j, 0, rand_param(), 0);
         end
   endtask

   task automatic command(op_type op, int sample);
      fill_params();
      send(op, 0, 0, 0, 0, sample);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.activation_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [12:0] rand_size();
      case ($urandom_range(0, 19))
         0: return 16;
         1: return 0;
         2: return 13'($urandom_range(17, 31));
         default: return 13'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic random_item();
      case ($urandom_range(0, 99)) inside
         [0:29]: send(OP_WRITE_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 15),
                      $urandom_range(0, 15), rand_param(), 0);
         [30:39]: send(OP_WRITE_BIAS, $urandom_range(0, 3), $urandom_range(0, 15), 0,
                       rand_param(), 0);
         [40:59]: send(OP_WRITE_INPUT, $urandom_range(0, 3), $urandom_range(0, 15),
                       $urandom_range(0, 15), 0, $urandom_range(0, 15));
         [60:84]: command(OP_FORWARD, $urandom_range(0, 15));
         [85:96]: command(OP_TRAIN, $urandom_range(0, 15));
         default: send(op_type'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST)),
                       $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 15),
                       rand_param(), $urandom_range(0, 15));
      endcase
   endtask

   initial begin
      cycle_count = 0;
      quiet = 0;
      stall_start = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_NUM_LAYERS;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_SIZE_LAYER0, 2);
      write_csr(CSR_SIZE_LAYER1, 3);
      write_csr(CSR_SIZE_LAYER2, 2);
      // train before any forward pass
      command(OP_TRAIN, 7);
      send(OP_WRITE_INPUT, 0, 0, 0, 0, -8);
      send(OP_WRITE_INPUT, 3, 1, 15, 0, 7);
      send(OP_WRITE_INPUT, 0, 15, 0, 0, 0);
      send(OP_WRITE_WEIGHT, 0, 15, 15, 32767, 0);
      send(OP_WRITE_BIAS, 0, 3, 0, -32768, 0);
      send(OP_WRITE_WEIGHT, 1, 0, 0, 32767, 0);
      send(OP_WRITE_WEIGHT, 1, 1, 1, -32768, 0);
      send(OP_WRITE_BIAS, 2, 1, 0, 32767, 0);
      command(OP_FORWARD, 0);
      command(OP_TRAIN, -8);
      command(OP_FORWARD, 0);
      for (int op = OP_UNKNOWN_FIRST; op <= OP_UNKNOWN_LAST; op++)
         send(op_type'(op), 3, 15, 15, -1, -1);
      command(OP_FORWARD, 0);
      settle();

      write_csr(CSR_NUM_LAYERS, 0);
      write_csr(CSR_SIZE_LAYER0, 0);
      write_csr(CSR_SIZE_LAYER1, 31);
      write_csr(CSR_LEARNING_RATE, 8191);
      command(OP_FORWARD, 0);
      command(OP_TRAIN, 7);
      command(OP_FORWARD, 0);
      settle();

      // four layers with full-width input and output layers, narrow middle
      write_csr(CSR_NUM_LAYERS, 7);
      write_csr(CSR_SIZE_LAYER0, 16);
      write_csr(CSR_SIZE_LAYER1, 2);
      write_csr(CSR_SIZE_LAYER2, 2);
      write_csr(CSR_SIZE_LAYER3, 16);
      write_csr(CSR_LEARNING_RATE, 0);
      command(OP_FORWARD, 0);
      command(OP_TRAIN, 7);
      command(OP_FORWARD, 0);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         write_csr(CSR_NUM_LAYERS, ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 7))
                                                              : 13'($urandom_range(2, 4)));
         write_csr(CSR_SIZE_LAYER0, rand_size());
         write_csr(CSR_SIZE_LAYER1, rand_size());
         write_csr(CSR_SIZE_LAYER2, rand_size());
         write_csr(CSR_SIZE_LAYER3, rand_size());
         write_csr(CSR_LEARNING_RATE,
                   ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                               : 13'($urandom_range(0, 4096)));
         quiet = (phase == 3);
         if (phase == 5) begin
            stall_start = 1;
            for (int i = 0; i < 12; i++) command(OP_FORWARD, 0);
         end
         for (int i = 0; i < 16; i++) random_item();
         quiet = 0;
         settle();
      end

      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/mst_pkg.sv
src/mst_chan_if.sv
src/mst_act_unit.sv
src/mlp_sigmoid_train_engine.sv
sim/mlp_sigmoid_train_engine_tb.sv
